### rtl/core/mpsd_pkg.sv
package mpsd_pkg;

	localparam int NUM_CH   = 4;
	localparam int SAMPLE_W = 16;
	localparam int DT_W     = 16;
	localparam int COUNT_W  = 16;
	localparam int LIMIT_W  = 16;
	localparam int TIME_W   = 32;
	localparam int REQ_W    = 16;
	localparam int MODE_W   = 2;
	localparam int CFG_W    = 64;
	localparam int IDX_W    = 3;
	localparam int ACNT_W   = $clog2(NUM_CH + 1);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MIN_LEVELS    = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_LEVELS    = 3'd1;
	localparam logic [IDX_W-1:0] REG_CHANNEL_MODES = 3'd2;
	localparam logic [IDX_W-1:0] REG_COUNT_LIMITS  = 3'd3;
	localparam logic [IDX_W-1:0] REG_REQUIRED_TIME = 3'd4;
	localparam logic [IDX_W-1:0] REG_PULSE_TIMEOUT = 3'd5;
	localparam logic [IDX_W-1:0] REG_RUNNING       = 3'd6;

	localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OR     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AND    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOT    = 2'd3;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [REQ_W-1:0]  REQ_TIME_RESET = 16'd10;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET  = 32'd100000;
	localparam int                ACNT_AND_MIN   = 2;

	typedef struct packed {
		logic clear;
		logic start;
		logic step;
	} lane_ctl_t;

	typedef struct packed {
		logic above;
		logic pos;
	} lane_stat_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

### rtl/core/mpsd_if.sv
interface mpsd_smp_if import mpsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [SAMPLE_W-1:0] level_ch0;
	logic [SAMPLE_W-1:0] level_ch1;
	logic [SAMPLE_W-1:0] level_ch2;
	logic [SAMPLE_W-1:0] level_ch3;
	logic [DT_W-1:0]     sample_time;

	modport source (output valid, kind, level_ch0, level_ch1, level_ch2, level_ch3,
		sample_time, input ready);
	modport sink (input valid, kind, level_ch0, level_ch1, level_ch2, level_ch3,
		sample_time, output ready);
endinterface

interface mpsd_res_if import mpsd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               capture;
	logic [NUM_CH-1:0]  positive_mask;
	logic               timed_out;
	logic [COUNT_W-1:0] tally_ch0;
	logic [COUNT_W-1:0] tally_ch1;
	logic [COUNT_W-1:0] tally_ch2;
	logic [COUNT_W-1:0] tally_ch3;

	modport source (output valid, capture, positive_mask, timed_out, tally_ch0, tally_ch1,
		tally_ch2, tally_ch3, input ready);
	modport sink (input valid, capture, positive_mask, timed_out, tally_ch0, tally_ch1,
		tally_ch2, tally_ch3, output ready);
endinterface

### rtl/core/mpsd_lane.sv
module mpsd_lane import mpsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lane_ctl_t           ctl,
	input  logic [SAMPLE_W-1:0] level,
	input  logic [DT_W-1:0]     dt,
	input  logic [SAMPLE_W-1:0] min_level,
	input  logic [SAMPLE_W-1:0] max_level,
	input  logic [REQ_W-1:0]    req_time,
	output lane_stat_t          stat
);

	logic [TIME_W-1:0]   time_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [TIME_W-1:0]   time_next;
	logic [SAMPLE_W-1:0] peak_next;
	logic [TIME_W-1:0]   dt_ext;
	logic                above;

	assign dt_ext    = {{(TIME_W-DT_W){1'b0}}, dt};
	assign above     = level >= min_level;
	assign time_next = above ? sat_add(time_q, dt_ext) : time_q;
	assign peak_next = (above && level > peak_q) ? level : peak_q;

	// judged on the values this sample leaves behind
	assign stat.above = above;
	assign stat.pos   = (time_next >= {{(TIME_W-REQ_W){1'b0}}, req_time}) &&
		(peak_next <= max_level);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			peak_q <= '0;
		end else if (ctl.clear) begin
			time_q <= '0;
			peak_q <= '0;
		end else if (ctl.start) begin
			// first sample of a pulse sets the time only
			time_q <= above ? dt_ext : '0;
		end else if (ctl.step) begin
			time_q <= time_next;
			peak_q <= peak_next;
		end
	end

endmodule

### rtl/core/multichannel_pulse_sort_decider_unit.sv
// Pulse sort decider for four detector channels. Each item on smp is one sample of all
// channels plus the time it took (kind 1 clears the tallies and any pulse in progress).
// Through a pulse each channel tracks time at or above its minimum level and its peak;
// when no active channel is above any more, or the accumulated pulse time passes
// pulse_timeout, one item on res reports the per-channel verdict, the capture decision
// and the tallies after the event. All other samples produce no item. The block takes one
// item every cycle unless smp stalls: the accepted item sits in one input register, is
// decided by short logic against the pulse state, and its result is registered in the output
// register. smp stalls only while a result waits in that register, res is not ready and the
// item in the input register closes another pulse. Write configuration only while the block
// is idle.
module multichannel_pulse_sort_decider_unit import mpsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mpsd_smp_if.sink          smp,
	mpsd_res_if.source        res,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]  wr_data
);

	// configuration
	logic [CFG_W-1:0]         min_levels_q;
	logic [CFG_W-1:0]         max_levels_q;
	logic [MODE_W*NUM_CH-1:0] modes_q;
	logic [CFG_W-1:0]         count_limits_q;
	logic [REQ_W-1:0]         req_time_q;
	logic [TIME_W-1:0]        timeout_q;
	logic                     running_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_levels_q   <= '1;
			max_levels_q   <= '1;
			modes_q        <= '0;
			count_limits_q <= '1;
			req_time_q     <= REQ_TIME_RESET;
			timeout_q      <= TIMEOUT_RESET;
			running_q      <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MIN_LEVELS:    min_levels_q   <= wr_data;
				REG_MAX_LEVELS:    max_levels_q   <= wr_data;
				REG_CHANNEL_MODES: modes_q        <= wr_data[MODE_W*NUM_CH-1:0];
				REG_COUNT_LIMITS:  count_limits_q <= wr_data;
				REG_REQUIRED_TIME: req_time_q     <= wr_data[REQ_W-1:0];
				REG_PULSE_TIMEOUT: timeout_q      <= wr_data[TIME_W-1:0];
				REG_RUNNING:       running_q      <= wr_data[0];
				default: ;
			endcase
		end
	end

	// input stage
	logic                valid_s1;
	logic                kind_s1;
	logic [SAMPLE_W-1:0] level_s1 [NUM_CH];
	logic [DT_W-1:0]     dt_s1;
	logic                advance;

	assign smp.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp.valid && smp.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.valid && smp.ready) begin
			kind_s1     <= smp.kind;
			level_s1[0] <= smp.level_ch0;
			level_s1[1] <= smp.level_ch1;
			level_s1[2] <= smp.level_ch2;
			level_s1[3] <= smp.level_ch3;
			dt_s1       <= smp.sample_time;
		end
	end

	// pulse state
	logic                in_pulse_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [COUNT_W-1:0]  tally_q [NUM_CH];

	lane_ctl_t           ctl;
	lane_stat_t          stat [NUM_CH];
	logic [NUM_CH-1:0]   above;
	logic [NUM_CH-1:0]   active;
	logic [NUM_CH-1:0]   is_or;
	logic [NUM_CH-1:0]   is_and;
	logic [NUM_CH-1:0]   is_not;
	logic [NUM_CH-1:0]   pos;
	logic [NUM_CH-1:0]   blocked;
	logic [ACNT_W-1:0]   and_cnt;
	logic [TIME_W-1:0]   elapsed_next;
	logic [COUNT_W-1:0]  tally_next [NUM_CH];
	logic                is_clear;
	logic                act;
	logic                entry;
	logic                tmo;
	logic                judge;
	logic                and_all;
	logic                capture;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		mpsd_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.level     (level_s1[i]),
			.dt        (dt_s1),
			.min_level (min_levels_q[SAMPLE_W*i +: SAMPLE_W]),
			.max_level (max_levels_q[SAMPLE_W*i +: SAMPLE_W]),
			.req_time  (req_time_q),
			.stat      (stat[i])
		);

		assign above[i]   = stat[i].above;
		assign active[i]  = modes_q[MODE_W*i +: MODE_W] != MODE_IGNORE;
		assign is_or[i]   = modes_q[MODE_W*i +: MODE_W] == MODE_OR;
		assign is_and[i]  = modes_q[MODE_W*i +: MODE_W] == MODE_AND;
		assign is_not[i]  = modes_q[MODE_W*i +: MODE_W] == MODE_NOT;
		// a timeout judges cleared times and peaks
		assign pos[i]     = tmo ? (req_time_q == '0) : stat[i].pos;
		assign blocked[i] = pos[i] && (tally_q[i] >= count_limits_q[LIMIT_W*i +: LIMIT_W]);
		assign tally_next[i] = (capture && pos[i] && tally_q[i] != {COUNT_W{1'b1}}) ?
			tally_q[i] + COUNT_W'(1) : tally_q[i];
	end

	assign is_clear     = kind_s1 == KIND_CLEAR;
	assign act          = valid_s1 && !is_clear && running_q;
	assign entry        = |(above & active);
	assign elapsed_next = sat_add(elapsed_q, {{(TIME_W-DT_W){1'b0}}, dt_s1});
	assign tmo          = in_pulse_q && (elapsed_next > timeout_q);
	assign judge        = act && in_pulse_q && (tmo || !entry);
	assign advance      = valid_s1 && (!judge || !res.valid || res.ready);

	always_comb begin
		and_cnt = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			and_cnt = and_cnt + ACNT_W'(pos[i] && is_and[i]);
		end
	end

	assign and_all = &(pos | ~is_and);
	assign capture = !(|(pos & is_not)) &&
		((|(pos & is_or)) || (and_all && and_cnt >= ACNT_W'(ACNT_AND_MIN))) &&
		!(|blocked);

	assign ctl.clear = advance && (is_clear || judge);
	assign ctl.start = advance && act && !in_pulse_q && entry;
	assign ctl.step  = advance && act && in_pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q <= 1'b0;
			elapsed_q  <= '0;
		end else if (ctl.clear) begin
			in_pulse_q <= 1'b0;
			elapsed_q  <= '0;
		end else if (ctl.start) begin
			in_pulse_q <= 1'b1;
			elapsed_q  <= '0;
		end else if (ctl.step) begin
			elapsed_q  <= elapsed_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				tally_q[i] <= '0;
			end
		end else if (advance && is_clear) begin
			for (int i = 0; i < NUM_CH; i++) begin
				tally_q[i] <= '0;
			end
		end else if (advance && judge) begin
			tally_q <= tally_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (advance && judge) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && judge) begin
			res.capture       <= capture;
			res.positive_mask <= pos;
			res.timed_out     <= tmo;
			res.tally_ch0     <= tally_next[0];
			res.tally_ch1     <= tally_next[1];
			res.tally_ch2     <= tally_next[2];
			res.tally_ch3     <= tally_next[3];
		end
	end

	// a capture needs at least one positive channel
	a_capture_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.capture |-> res.positive_mask != '0)
		else $error("capture with empty positive mask");

	a_idle_elapsed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_pulse_q |-> elapsed_q == '0)
		else $error("pulse time held outside a pulse");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_clear |=> !in_pulse_q && tally_q[0] == '0 && tally_q[NUM_CH-1] == '0)
		else $error("clear item left state behind");

	a_judge_ends_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		advance && judge |=> !in_pulse_q && res.valid)
		else $error("judged pulse did not end with a result");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready && valid_s1 && judge |-> !advance)
		else $error("result overwritten while stalled");

endmodule
